// ===== rtl/mts_pkg.sv =====
// ----------------------------------------------------------------------------
// mts_pkg: shared definitions for the max tracking stack
// Depth, widths, command and status codes, and the structs between the top
// level and the stack lanes.
// ----------------------------------------------------------------------------
package mts_pkg;

  localparam int DEPTH    = 1024;
  localparam int DataW    = 32;
  localparam int AddrW    = $clog2(DEPTH);
  localparam int CntW     = $clog2(DEPTH + 1);
  localparam int CapW     = 11;
  localparam int CmpW     = (CntW > CapW) ? CntW : CapW;
  localparam int StatusW  = 2;

  localparam logic [CapW-1:0] CapReset = CapW'(1024);

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  localparam logic [StatusW-1:0] ST_OK  = 2'd0;
  localparam logic [StatusW-1:0] ST_OVF = 2'd1;
  localparam logic [StatusW-1:0] ST_UNF = 2'd2;

  // request into one stack lane
  typedef struct packed {
    logic                    push;
    logic                    pop;
    logic signed [DataW-1:0] data;
  } lane_ctrl_t;

  // view of one stack lane: top entry, the entry below it and the fill
  typedef struct packed {
    logic signed [DataW-1:0] top;
    logic signed [DataW-1:0] below;
    logic [CntW-1:0]         count;
  } lane_stat_t;

endpackage

// ===== rtl/max_tracking_stack.sv =====
// ----------------------------------------------------------------------------
// max_tracking_stack: stack of signed words that reports its maximum
// Push and pop commands with one result word per command.
// ----------------------------------------------------------------------------
// A new command word is taken every clock cycle while in_stall_o is low; the
// command waits in the input register until the result register is free, then
// the result register holds its result word until it is taken. The
// stack tops are kept in flops and each ram prefetches the entry under its
// top, so back to back pushes and pops need no wait. Each result gives the
// status (ok, overflow, underflow), the popped word and the maximum after the
// command. The capacity register (reset 1024, clipped to the depth) may only
// be written while no command is in flight.
module max_tracking_stack (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [mts_pkg::CapW-1:0]       cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           command_i,
  input  logic signed [mts_pkg::DataW-1:0] push_value_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [mts_pkg::StatusW-1:0]    status_o,
  output logic signed [mts_pkg::DataW-1:0] popped_value_o,
  output logic signed [mts_pkg::DataW-1:0] current_max_o,
  output logic                           max_valid_o
);
  import mts_pkg::*;

  logic [CapW-1:0]         cap_q;
  logic                    in_vld_q, in_vld_d;
  logic                    cmd_q;
  logic signed [DataW-1:0] val_q;
  logic                    out_vld_q, out_vld_d;
  logic [StatusW-1:0]      status_q, status_d;
  logic signed [DataW-1:0] popped_q, popped_d;
  logic signed [DataW-1:0] max_q, max_d;
  logic                    mvld_q, mvld_d;

  logic       accept, exec, is_push, full, empty, m_empty, m_full, copy;
  logic       do_push, do_pop;
  logic [CmpW-1:0] cnt_x, cap_x;
  logic [CntW-1:0] v_cnt_n, m_cnt_n;
  logic signed [DataW-1:0] m_top_n;
  lane_ctrl_t v_ctrl, m_ctrl;
  lane_stat_t v_stat, m_stat;

  assign exec       = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !exec;
  assign accept     = in_valid_i && !in_stall_o;

  assign is_push = (cmd_q == CMD_PUSH);
  assign cnt_x   = CmpW'(v_stat.count);
  assign cap_x   = CmpW'(cap_q);
  assign full    = (cnt_x >= cap_x) || (cnt_x >= CmpW'(DEPTH));
  assign empty   = (v_stat.count == '0);
  assign m_empty = (m_stat.count == '0);
  assign m_full  = (m_stat.count >= CntW'(DEPTH));
  assign copy    = m_empty || (val_q >= m_stat.top);
  assign do_push = exec && is_push && !full;
  assign do_pop  = exec && !is_push && !empty;

  assign v_ctrl.push = do_push;
  assign v_ctrl.pop  = do_pop;
  assign v_ctrl.data = val_q;
  assign m_ctrl.push = do_push && copy && !m_full;
  assign m_ctrl.pop  = do_pop && !m_empty && (m_stat.top == v_stat.top);
  assign m_ctrl.data = val_q;

  mts_lane u_values (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctrl_i(v_ctrl),
    .stat_o(v_stat)
  );

  mts_lane u_maxima (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctrl_i(m_ctrl),
    .stat_o(m_stat)
  );

  // state after this command, as seen by the result word
  always_comb begin
    v_cnt_n = v_stat.count;
    m_cnt_n = m_stat.count;
    m_top_n = m_stat.top;
    if (v_ctrl.push) begin
      v_cnt_n = v_stat.count + CntW'(1);
    end else if (v_ctrl.pop) begin
      v_cnt_n = v_stat.count - CntW'(1);
    end
    if (m_ctrl.push) begin
      m_cnt_n = m_stat.count + CntW'(1);
      m_top_n = val_q;
    end else if (m_ctrl.pop) begin
      m_cnt_n = m_stat.count - CntW'(1);
      m_top_n = m_stat.below;
    end
  end

  always_comb begin
    if (is_push) begin
      status_d = full ? ST_OVF : ST_OK;
    end else begin
      status_d = empty ? ST_UNF : ST_OK;
    end
    popped_d = do_pop ? v_stat.top : '0;
    mvld_d   = (v_cnt_n != '0);
    max_d    = (mvld_d && (m_cnt_n != '0)) ? m_top_n : '0;
  end

  always_comb begin
    in_vld_d = in_vld_q;
    if (accept) begin
      in_vld_d = 1'b1;
    end else if (exec) begin
      in_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (exec) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q     <= CapReset;
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= command_i;
      val_q <= push_value_i;
    end
    if (exec) begin
      status_q <= status_d;
      popped_q <= popped_d;
      max_q    <= max_d;
      mvld_q   <= mvld_d;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign status_o       = status_q;
  assign popped_value_o = popped_q;
  assign current_max_o  = max_q;
  assign max_valid_o    = mvld_q;

  // maxima stack never holds more than the value stack
  a_maxima_le_values: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_stat.count <= v_stat.count)
    else $error("maxima stack deeper than value stack");

  a_empty_together: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_stat.count == '0) |-> (m_stat.count == '0))
    else $error("maxima left behind on empty stack");

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_stat.count <= CntW'(DEPTH))
    else $error("value stack beyond depth");

  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_pop |=> (v_stat.count == $past(v_stat.count) - CntW'(1)))
    else $error("pop did not remove one entry");

  a_underflow_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == ST_UNF)) |-> (popped_value_o == '0 && !max_valid_o))
    else $error("underflow word carries data");

endmodule

// ===== rtl/mts_ram.sv =====
// ----------------------------------------------------------------------------
// mts_ram: generic single write, single read ram
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module mts_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/mts_lane.sv =====
// ----------------------------------------------------------------------------
// mts_lane: one stack with its top held in registers
// The top lives in flops, as does a copy of the entry below it after a push;
// deeper entries sit in a ram that always reads the slot below the next top.
// ----------------------------------------------------------------------------
module mts_lane (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mts_pkg::lane_ctrl_t ctrl_i,
  output mts_pkg::lane_stat_t stat_o
);
  import mts_pkg::*;

  logic [CntW-1:0]         count_q, count_d;
  logic signed [DataW-1:0] top_q, top_d;
  logic signed [DataW-1:0] hold_q, hold_d;
  logic                    sel_q, sel_d;
  logic signed [DataW-1:0] below;
  logic [DataW-1:0]        rdata;
  logic [CntW-1:0]         cnt_m1, cnt_m2;
  logic                    we;

  // after a push the slot below the top is being written, so take it from hold
  assign below  = sel_q ? hold_q : $signed(rdata);
  assign cnt_m1 = count_q - CntW'(1);
  assign cnt_m2 = count_d - CntW'(2);
  assign we     = ctrl_i.push && (count_q != '0);

  always_comb begin
    count_d = count_q;
    top_d   = top_q;
    hold_d  = hold_q;
    sel_d   = sel_q;
    priority if (ctrl_i.push) begin
      count_d = count_q + CntW'(1);
      top_d   = ctrl_i.data;
      hold_d  = top_q;
      sel_d   = 1'b1;
    end else if (ctrl_i.pop) begin
      count_d = cnt_m1;
      top_d   = below;
      sel_d   = 1'b0;
    end
  end

  mts_ram #(
    .Width(DataW),
    .Depth(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(cnt_m1[AddrW-1:0]),
    .wdata_i(top_q),
    .raddr_i(cnt_m2[AddrW-1:0]),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      sel_q   <= 1'b0;
    end else begin
      count_q <= count_d;
      sel_q   <= sel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q  <= top_d;
    hold_q <= hold_d;
  end

  assign stat_o.top   = top_q;
  assign stat_o.below = below;
  assign stat_o.count = count_q;

endmodule
